/* rtl/tle_pkg.sv */
// Shared types, codes and constants of the terminal line editor.
`default_nettype none

package tle_pkg;

    localparam int LINE_LEN_DEF = 32;
    localparam int CFG_IDX_W    = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_FORMAT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAW_MODE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CANON_MODE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ECHO_ON     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INTR_ENABLE = 3'd4;

    // Editing keys.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_INTR   = 8'h03;
    localparam logic [7:0] CH_EOF    = 8'h04;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_KILL   = 8'h15;
    localparam logic [7:0] CH_LNEXT  = 8'h16;
    localparam logic [7:0] CH_WERASE = 8'h17;

    localparam logic [1:0] DEST_EVENT  = 2'd0;
    localparam logic [1:0] DEST_READER = 2'd1;
    localparam logic [1:0] DEST_TERM   = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_PASS,
        S_ECHO,
        S_INTR,
        S_EOF,
        S_FL_RD,
        S_FL_OUT,
        S_APPEND,
        S_SEQ,
        S_WE_RD,
        S_WE_CHK
    } t_state;

    typedef enum logic [2:0] {
        EM_RD_BYTE,
        EM_RD_DATA,
        EM_TERM_BYTE,
        EM_TERM_BS,
        EM_TERM_SEQ,
        EM_INTR,
        EM_EOF
    } t_emit;

    typedef enum logic [1:0] {
        SQ_BS,
        SQ_EOL,
        SQ_KILL
    } t_seq;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  load_byte;
        logic  lit_set;
        logic  lit_clr;
        logic  cnt_clr;
        logic  cnt_dec;
        logic  app_wr;
        logic  app_nl;
        logic  rd_flush;
        logic  rd_word;
        logic  idx_clr;
        logic  idx_inc;
        logic  seq_load;
        t_seq  seq_sel;
        logic  seq_inc;
        logic  emit;
        t_emit emit_kind;
        logic  emit_last;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       bypass;
        logic       canon;
        logic       echo_on;
        logic       intr_en;
        logic       lit;
        logic       cnt_zero;
        logic       cnt_full;
        logic       fl_done;
        logic       fl_final;
        logic       rd_alnum;
        logic       seq_end;
        logic       out_free;
    } t_sts;

endpackage

`default_nettype wire

/* rtl/tle_dp.sv */
// Datapath of the line editor: mode registers, line store, counters and output register.
`default_nettype none

module tle_dp #(
    parameter int LINE_LEN = tle_pkg::LINE_LEN_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [tle_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [0:0]                   i_cfg_data,
    input  wire logic [7:0]                   i_in_byte,
    input  wire tle_pkg::t_cmd                i_cmd,
    output tle_pkg::t_sts                     o_sts,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic [1:0]                        o_dest,
    output logic [7:0]                        o_out_byte,
    output logic                              o_eof_mark,
    output logic                              o_intr,
    output logic                              o_last
);
    import tle_pkg::*;

    localparam int CW = $clog2(LINE_LEN + 1);
    localparam int AW = $clog2(LINE_LEN);

    localparam logic [3:0] SEQ_BS_FIRST   = 4'd0;
    localparam logic [3:0] SEQ_BS_LAST    = 4'd2;
    localparam logic [3:0] SEQ_EOL_FIRST  = 4'd3;
    localparam logic [3:0] SEQ_EOL_LAST   = 4'd5;
    localparam logic [3:0] SEQ_KILL_FIRST = 4'd6;
    localparam logic [3:0] SEQ_KILL_LAST  = 4'd13;

    // Fixed terminal sequences: BS SP BS, then erase to end of line, then erase line and home.
    function automatic logic [7:0] seq_byte(input logic [3:0] i);
        logic [7:0] b;
        case (i)
            4'd0:    b = 8'h08;
            4'd1:    b = 8'h20;
            4'd2:    b = 8'h08;
            4'd3:    b = 8'h1B;
            4'd4:    b = 8'h5B;
            4'd5:    b = 8'h4B;
            4'd6:    b = 8'h1B;
            4'd7:    b = 8'h5B;
            4'd8:    b = 8'h32;
            4'd9:    b = 8'h4B;
            4'd10:   b = 8'h1B;
            4'd11:   b = 8'h5B;
            4'd12:   b = 8'h30;
            4'd13:   b = 8'h47;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A);
    endfunction

    logic          r_text;
    logic          r_raw;
    logic          r_canon;
    logic          r_echo;
    logic          r_intr_en;
    logic          r_lit;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_idx;
    logic [3:0]    r_sp;
    logic [3:0]    r_se;
    logic [7:0]    r_byte;
    logic [7:0]    r_rdata;
    logic [7:0]    mem [LINE_LEN];
    logic          r_ovalid;
    logic [1:0]    r_dest;
    logic [7:0]    r_obyte;
    logic          r_eof;
    logic          r_intr;
    logic          r_last;

    logic [CW-1:0] cnt_m1;
    logic [CW-1:0] idx_p1;
    logic [AW-1:0] raddr;
    logic          out_free;

    assign cnt_m1   = r_count - CW'(1);
    assign idx_p1   = r_idx + CW'(1);
    assign raddr    = i_cmd.rd_word ? cnt_m1[AW-1:0] : r_idx[AW-1:0];
    assign out_free = !r_ovalid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text    <= 1'b1;
            r_raw     <= 1'b0;
            r_canon   <= 1'b1;
            r_echo    <= 1'b1;
            r_intr_en <= 1'b0;
            r_lit     <= 1'b0;
            r_count   <= '0;
            r_idx     <= '0;
            r_sp      <= '0;
            r_se      <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TEXT_FORMAT: r_text    <= i_cfg_data[0];
                    CFG_RAW_MODE:    r_raw     <= i_cfg_data[0];
                    CFG_CANON_MODE:  r_canon   <= i_cfg_data[0];
                    CFG_ECHO_ON:     r_echo    <= i_cfg_data[0];
                    CFG_INTR_ENABLE: r_intr_en <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.lit_set) begin
                r_lit <= 1'b1;
            end else if (i_cmd.lit_clr) begin
                r_lit <= 1'b0;
            end
            if (i_cmd.cnt_clr) begin
                r_count <= '0;
            end else if (i_cmd.cnt_dec) begin
                r_count <= cnt_m1;
            end else if (i_cmd.app_wr) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= idx_p1;
            end
            if (i_cmd.seq_load) begin
                case (i_cmd.seq_sel)
                    SQ_BS: begin
                        r_sp <= SEQ_BS_FIRST;
                        r_se <= SEQ_BS_LAST;
                    end
                    SQ_EOL: begin
                        r_sp <= SEQ_EOL_FIRST;
                        r_se <= SEQ_EOL_LAST;
                    end
                    default: begin
                        r_sp <= SEQ_KILL_FIRST;
                        r_se <= SEQ_KILL_LAST;
                    end
                endcase
            end else if (i_cmd.seq_inc) begin
                r_sp <= r_sp + 4'd1;
            end
            if (i_cmd.emit) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_byte) begin
            r_byte <= i_in_byte;
        end
        if (i_cmd.app_wr) begin
            mem[r_count[AW-1:0]] <= i_cmd.app_nl ? CH_NL : r_byte;
        end
        if (i_cmd.rd_flush || i_cmd.rd_word) begin
            r_rdata <= mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_last <= i_cmd.emit_last;
            r_eof  <= 1'b0;
            r_intr <= 1'b0;
            case (i_cmd.emit_kind)
                EM_RD_BYTE: begin
                    r_dest  <= DEST_READER;
                    r_obyte <= r_byte;
                end
                EM_RD_DATA: begin
                    r_dest  <= DEST_READER;
                    r_obyte <= r_rdata;
                end
                EM_TERM_BYTE: begin
                    r_dest  <= DEST_TERM;
                    r_obyte <= r_byte;
                end
                EM_TERM_BS: begin
                    r_dest  <= DEST_TERM;
                    r_obyte <= CH_BS;
                end
                EM_TERM_SEQ: begin
                    r_dest  <= DEST_TERM;
                    r_obyte <= seq_byte(r_sp);
                end
                EM_INTR: begin
                    r_dest  <= DEST_EVENT;
                    r_obyte <= 8'h00;
                    r_intr  <= 1'b1;
                end
                default: begin
                    r_dest  <= DEST_EVENT;
                    r_obyte <= 8'h00;
                    r_eof   <= 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        o_sts.in_byte  = r_byte;
        o_sts.bypass   = !r_text || r_raw;
        o_sts.canon    = r_canon;
        o_sts.echo_on  = r_echo;
        o_sts.intr_en  = r_intr_en;
        o_sts.lit      = r_lit;
        o_sts.cnt_zero = (r_count == '0);
        o_sts.cnt_full = (r_count == CW'(LINE_LEN));
        o_sts.fl_done  = (r_idx == r_count);
        o_sts.fl_final = (idx_p1 == r_count);
        o_sts.rd_alnum = is_alnum(r_rdata);
        o_sts.seq_end  = (r_sp == r_se);
        o_sts.out_free = out_free;
    end

    assign o_valid    = r_ovalid;
    assign o_dest     = r_dest;
    assign o_out_byte = r_obyte;
    assign o_eof_mark = r_eof;
    assign o_intr     = r_intr;
    assign o_last     = r_last;

    // A new result is only loaded when the output register is empty or being taken.
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> out_free)
        else $error("result loaded over a waiting result");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(LINE_LEN))
        else $error("line count beyond line length");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.rd_flush || i_cmd.idx_inc) |-> (r_idx < r_count))
        else $error("flush index past end of line");

endmodule

`default_nettype wire

/* rtl/tle_ctrl.sv */
// Controller state machine of the line editor: decodes each byte and sequences its results.
`default_nettype none

module tle_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire tle_pkg::t_sts i_sts,
    output tle_pkg::t_cmd      o_cmd
);
    import tle_pkg::*;

    t_state r_state;
    t_state n_state;
    t_state r_ret;
    t_state n_ret;
    logic   r_fl_last;
    logic   n_fl_last;
    logic   r_nl;
    logic   n_nl;
    t_cmd   cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ret     <= S_IDLE;
            r_fl_last <= 1'b0;
            r_nl      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ret     <= n_ret;
            r_fl_last <= n_fl_last;
            r_nl      <= n_nl;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_ret     = r_ret;
        n_fl_last = r_fl_last;
        n_nl      = r_nl;

        cmd.load_byte = 1'b0;
        cmd.lit_set   = 1'b0;
        cmd.lit_clr   = 1'b0;
        cmd.cnt_clr   = 1'b0;
        cmd.cnt_dec   = 1'b0;
        cmd.app_wr    = 1'b0;
        cmd.app_nl    = r_nl;
        cmd.rd_flush  = 1'b0;
        cmd.rd_word   = 1'b0;
        cmd.idx_clr   = 1'b0;
        cmd.idx_inc   = 1'b0;
        cmd.seq_load  = 1'b0;
        cmd.seq_sel   = SQ_BS;
        cmd.seq_inc   = 1'b0;
        cmd.emit      = 1'b0;
        cmd.emit_kind = EM_RD_BYTE;
        cmd.emit_last = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    cmd.load_byte = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.bypass || !i_sts.canon) begin
                    n_state = S_PASS;
                end else if (i_sts.lit) begin
                    // A quoted byte is stored as is, whatever key it is.
                    cmd.lit_clr = 1'b1;
                    n_nl        = 1'b0;
                    if (i_sts.cnt_full) begin
                        cmd.idx_clr = 1'b1;
                        n_ret       = S_APPEND;
                        n_fl_last   = !i_sts.echo_on;
                        n_state     = S_FL_RD;
                    end else begin
                        n_state = S_APPEND;
                    end
                end else begin
                    case (i_sts.in_byte)
                        CH_INTR: begin
                            n_state = i_sts.intr_en ? S_INTR : S_IDLE;
                        end
                        CH_EOF: begin
                            if (i_sts.cnt_zero) begin
                                n_state = S_EOF;
                            end else begin
                                cmd.idx_clr = 1'b1;
                                n_ret       = S_IDLE;
                                n_fl_last   = 1'b1;
                                n_state     = S_FL_RD;
                            end
                        end
                        CH_BS: begin
                            if (i_sts.cnt_zero) begin
                                n_state = S_IDLE;
                            end else begin
                                cmd.cnt_dec  = 1'b1;
                                cmd.seq_load = 1'b1;
                                cmd.seq_sel  = SQ_BS;
                                n_state      = S_SEQ;
                            end
                        end
                        CH_WERASE: begin
                            n_state = S_WE_RD;
                        end
                        CH_KILL: begin
                            cmd.cnt_clr  = 1'b1;
                            cmd.seq_load = 1'b1;
                            cmd.seq_sel  = SQ_KILL;
                            n_state      = S_SEQ;
                        end
                        CH_LNEXT: begin
                            cmd.lit_set = 1'b1;
                            n_state     = S_IDLE;
                        end
                        CH_NUL, CH_NL: begin
                            n_nl = 1'b1;
                            if (i_sts.cnt_full) begin
                                cmd.idx_clr = 1'b1;
                                n_ret       = S_APPEND;
                                n_fl_last   = 1'b0;
                                n_state     = S_FL_RD;
                            end else begin
                                n_state = S_APPEND;
                            end
                        end
                        default: begin
                            n_nl = 1'b0;
                            if (i_sts.cnt_full) begin
                                cmd.idx_clr = 1'b1;
                                n_ret       = S_APPEND;
                                n_fl_last   = !i_sts.echo_on;
                                n_state     = S_FL_RD;
                            end else begin
                                n_state = S_APPEND;
                            end
                        end
                    endcase
                end
            end
            S_PASS: begin
                if (i_sts.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = EM_RD_BYTE;
                    cmd.emit_last = i_sts.bypass || !i_sts.echo_on;
                    n_state = (!i_sts.bypass && i_sts.echo_on) ? S_ECHO : S_IDLE;
                end
            end
            S_ECHO: begin
                if (i_sts.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = EM_TERM_BYTE;
                    cmd.emit_last = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_INTR: begin
                if (i_sts.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = EM_INTR;
                    cmd.emit_last = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_EOF: begin
                if (i_sts.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = EM_EOF;
                    cmd.emit_last = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_FL_RD: begin
                if (i_sts.fl_done) begin
                    cmd.cnt_clr = 1'b1;
                    n_state     = r_ret;
                end else begin
                    cmd.rd_flush = 1'b1;
                    n_state      = S_FL_OUT;
                end
            end
            S_FL_OUT: begin
                if (i_sts.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = EM_RD_DATA;
                    cmd.emit_last = r_fl_last && i_sts.fl_final;
                    cmd.idx_inc   = 1'b1;
                    n_state       = S_FL_RD;
                end
            end
            S_APPEND: begin
                cmd.app_wr = 1'b1;
                if (r_nl) begin
                    // The newline completes the line, which goes out at once.
                    cmd.idx_clr = 1'b1;
                    n_ret       = i_sts.echo_on ? S_ECHO : S_IDLE;
                    n_fl_last   = !i_sts.echo_on;
                    n_state     = S_FL_RD;
                end else begin
                    n_state = i_sts.echo_on ? S_ECHO : S_IDLE;
                end
            end
            S_SEQ: begin
                if (i_sts.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = EM_TERM_SEQ;
                    cmd.emit_last = i_sts.seq_end;
                    cmd.seq_inc   = 1'b1;
                    if (i_sts.seq_end) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_WE_RD: begin
                if (i_sts.cnt_zero) begin
                    cmd.seq_load = 1'b1;
                    cmd.seq_sel  = SQ_EOL;
                    n_state      = S_SEQ;
                end else begin
                    cmd.cnt_dec = 1'b1;
                    cmd.rd_word = 1'b1;
                    n_state     = S_WE_CHK;
                end
            end
            S_WE_CHK: begin
                // The first byte that is not a letter or digit is dropped silently.
                if (i_sts.rd_alnum) begin
                    if (i_sts.out_free) begin
                        cmd.emit      = 1'b1;
                        cmd.emit_kind = EM_TERM_BS;
                        n_state       = S_WE_RD;
                    end
                end else begin
                    cmd.seq_load = 1'b1;
                    cmd.seq_sel  = SQ_EOL;
                    n_state      = S_SEQ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd   = cmd;
    assign o_stall = (r_state != S_IDLE);

    a_app_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.app_wr |-> !i_sts.cnt_full)
        else $error("append into a full line");

    a_dec_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.cnt_dec |-> !i_sts.cnt_zero)
        else $error("erase from an empty line");

    a_flush_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.rd_flush |=> (r_state == S_FL_OUT))
        else $error("flush read not followed by its output step");

endmodule

`default_nettype wire

/* rtl/tty_canonical_line_editor.sv */
// Top level of the terminal line editor: controller and datapath.
// An accepted request is registered, then decoded; a pass-through byte then goes out, while a
// newline is appended and its line flushed first. A request with no result frees the input once decoded.
// A pass-through or stored byte may then be echoed to the terminal; a line flush reads
// each stored byte from the line store, then outputs it, and word erase reads and checks each byte.
// Output stalls hold the controller. Reset is synchronous: modes return to text, canonical, echo on.
`default_nettype none

module tty_canonical_line_editor #(
    parameter int LINE_LEN = tle_pkg::LINE_LEN_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [tle_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [0:0]                    i_cfg_data,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [7:0]                    i_in_byte,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [1:0]                         o_dest,
    output logic [7:0]                         o_out_byte,
    output logic                               o_eof_mark,
    output logic                               o_intr,
    output logic                               o_last
);
    import tle_pkg::*;

    t_cmd cmd;
    t_sts sts;

    tle_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    tle_dp #(
        .LINE_LEN (LINE_LEN)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_byte  (i_in_byte),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_dest     (o_dest),
        .o_out_byte (o_out_byte),
        .o_eof_mark (o_eof_mark),
        .o_intr     (o_intr),
        .o_last     (o_last)
    );

endmodule

`default_nettype wire
